/* hw/rtl/fbc_pkg.sv */
// shared types, register indexes and round function of the 16-bit feistel cipher
package fbc_pkg;

    localparam int HALF_W  = 8;
    localparam int LEN_W   = 4;
    localparam int ROUND_W = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 8'd2;

    localparam logic [LEN_W-1:0]   KEY_LEN_RESET     = 4'd8;
    localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 8'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic zero_rounds;
        logic last_round;
    } sts_t;

    // low nibble s-box: (3^v mod 17 + 2) mod 16
    function automatic logic [3:0] sbox_lo(input logic [3:0] v);
        logic [3:0] s;
        case (v)
            4'd0:    s = 4'd3;
            4'd1:    s = 4'd5;
            4'd2:    s = 4'd11;
            4'd3:    s = 4'd12;
            4'd4:    s = 4'd15;
            4'd5:    s = 4'd7;
            4'd6:    s = 4'd1;
            4'd7:    s = 4'd13;
            4'd8:    s = 4'd2;
            4'd9:    s = 4'd0;
            4'd10:   s = 4'd10;
            4'd11:   s = 4'd9;
            4'd12:   s = 4'd6;
            4'd13:   s = 4'd14;
            4'd14:   s = 4'd4;
            default: s = 4'd8;
        endcase
        return s;
    endfunction

    // high nibble s-box: (5^v mod 17 + 7) mod 16
    function automatic logic [3:0] sbox_hi(input logic [3:0] v);
        logic [3:0] s;
        case (v)
            4'd0:    s = 4'd8;
            4'd1:    s = 4'd12;
            4'd2:    s = 4'd15;
            4'd3:    s = 4'd13;
            4'd4:    s = 4'd4;
            4'd5:    s = 4'd5;
            4'd6:    s = 4'd9;
            4'd7:    s = 4'd1;
            4'd8:    s = 4'd7;
            4'd9:    s = 4'd3;
            4'd10:   s = 4'd0;
            4'd11:   s = 4'd2;
            4'd12:   s = 4'd11;
            4'd13:   s = 4'd10;
            4'd14:   s = 4'd6;
            default: s = 4'd14;
        endcase
        return s;
    endfunction

    // key mix, substitution and rotate left by 3
    function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] r,
                                                   input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] t;
        logic [HALF_W-1:0] s;
        t = r ^ k;
        s = {sbox_hi(t[7:4]), sbox_lo(t[3:0])};
        return {s[4:0], s[7:5]};
    endfunction

endpackage

/* hw/rtl/fbc_ctrl.sv */
// controller state machine: request intake, round sequencing, output register handoff
module fbc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  fbc_pkg::sts_t sts,
    output fbc_pkg::cmd_t cmd
);
    import fbc_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.zero_rounds ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (sts.last_round) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // output slot free or draining this cycle
                if (!m_valid_reg || m_axis_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_axis_tready))
        else $error("output register overwritten");

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.emit))
        else $error("result shown without emit");

endmodule

/* hw/rtl/fbc_dp.sv */
// datapath: half registers, round and key byte counters, round function, output register
module fbc_dp #(
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fbc_pkg::cmd_t                       cmd,
    output fbc_pkg::sts_t                       sts,
    input  logic [fbc_pkg::HALF_W-1:0]          left_in,
    input  logic [fbc_pkg::HALF_W-1:0]          right_in,
    input  logic [MAX_KEY_BYTES*8-1:0]          key_bytes,
    input  logic [fbc_pkg::LEN_W-1:0]           key_len,
    input  logic [fbc_pkg::ROUND_W-1:0]         round_count,
    output logic [fbc_pkg::HALF_W-1:0]          left_out,
    output logic [fbc_pkg::HALF_W-1:0]          right_out
);
    import fbc_pkg::*;

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [HALF_W-1:0]  left_reg, left_next;
    logic [HALF_W-1:0]  right_reg, right_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [KIDX_W-1:0]  kidx_reg, kidx_next;
    logic [HALF_W-1:0]  lout_reg, rout_reg;

    logic [HALF_W-1:0]  key_arr [MAX_KEY_BYTES];
    logic [LEN_W-1:0]   len_eff;
    logic [HALF_W-1:0]  key_byte;
    logic               kidx_wrap;

    for (genvar j = 0; j < MAX_KEY_BYTES; j++) begin : g_key
        assign key_arr[j] = key_bytes[j*8 +: 8];
    end

    // zero means one key byte, beyond the store saturates
    always_comb begin
        if (key_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (key_len > LEN_W'(MAX_KEY_BYTES)) begin
            len_eff = LEN_W'(MAX_KEY_BYTES);
        end else begin
            len_eff = key_len;
        end
    end

    assign key_byte  = key_arr[kidx_reg];
    assign kidx_wrap = (LEN_W'(kidx_reg) == (len_eff - LEN_W'(1)));

    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        rnd_next   = rnd_reg;
        kidx_next  = kidx_reg;
        if (cmd.load) begin
            left_next  = left_in;
            right_next = right_in;
            rnd_next   = '0;
            kidx_next  = '0;
        end else if (cmd.step) begin
            left_next  = right_reg;
            right_next = round_fn(right_reg, key_byte) ^ left_reg;
            rnd_next   = rnd_reg + ROUND_W'(1);
            kidx_next  = kidx_wrap ? '0 : kidx_reg + KIDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_reg  <= '0;
            kidx_reg <= '0;
        end else begin
            rnd_reg  <= rnd_next;
            kidx_reg <= kidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        right_reg <= right_next;
        if (cmd.emit) begin
            lout_reg <= left_reg;
            rout_reg <= right_reg;
        end
    end

    assign sts.zero_rounds = (round_count == '0);
    assign sts.last_round  = (rnd_reg == round_count - ROUND_W'(1));

    assign left_out  = lout_reg;
    assign right_out = rout_reg;

    a_kidx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (LEN_W'(kidx_reg) < len_eff))
        else $error("key byte index beyond key length");

    a_load_clears_round: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (rnd_reg == '0 && kidx_reg == '0))
        else $error("round counters not cleared on load");

endmodule

/* hw/rtl/feistel_block_cipher_16bit.sv */
// top level of the 16-bit feistel cipher: config registers, controller and datapath
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata[15:0] = right_in, left_in
//  m_axis    out  m_axis_tvalid/tready        tdata[15:0] = right_out, left_out
//  cfg       in   cfg_valid/cfg_ready         cfg_index[7:0], cfg_data[63:0]
//
//  a request is loaded, runs its rounds one after another through the
//  single shared round unit, then moves into the output register once that is free or draining
//  a finished result waits in the output register while the next request is taken
//  aresetn is synchronous; it clears the state machine, counters and config to
//  key 0, key length 8, eight rounds; cfg writes are always accepted
module feistel_block_cipher_16bit #(
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // left_in [7:0], right_in [15:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // left_out [7:0], right_out [15:8]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import fbc_pkg::*;

    localparam int KEY_W = MAX_KEY_BYTES * 8;

    logic [KEY_W-1:0]   key_reg;
    logic [LEN_W-1:0]   key_len_reg;
    logic [ROUND_W-1:0] round_count_reg;

    cmd_t              cmd;
    sts_t              sts;
    logic [HALF_W-1:0] left_out, right_out;
    logic              cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // key bytes beyond the store are never selected
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg         <= '0;
            key_len_reg     <= KEY_LEN_RESET;
            round_count_reg <= ROUND_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY_BYTES:   key_reg         <= cfg_data[KEY_W-1:0];
                REG_KEY_LEN:     key_len_reg     <= cfg_data[LEN_W-1:0];
                REG_ROUND_COUNT: round_count_reg <= cfg_data[ROUND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fbc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    fbc_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .left_in     (s_axis_tdata[7:0]),
        .right_in    (s_axis_tdata[15:8]),
        .key_bytes   (key_reg),
        .key_len     (key_len_reg),
        .round_count (round_count_reg),
        .left_out    (left_out),
        .right_out   (right_out)
    );

    assign m_axis_tdata = {right_out, left_out};

endmodule

/* tb/fbc_checker.sv */
// checker for the 16-bit feistel cipher: tracks config writes, predicts each result and compares
module fbc_checker
    import fbc_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,     // left_in [7:0], right_in [15:8]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,     // left_out [7:0], right_out [15:8]
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  wrap_up,
    output int                    pending,
    output int                    fail_count
);

    typedef struct packed {
        logic [HALF_W-1:0] right_half;
        logic [HALF_W-1:0] left_half;
    } block_t;

    logic [3:0]            lo_tab [16];
    logic [3:0]            hi_tab [16];
    logic [CFG_DATA_W-1:0] key_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [ROUND_W-1:0]    rounds_reg;
    block_t                ciphertext_q [$];
    int                    mismatches = 0;
    bit                    wrapped = 1'b0;

    assign fail_count = mismatches;

    // (base^v mod 17 + offset) mod 16
    function automatic logic [3:0] pow_entry(input int base, input int offset, input int v);
        int p;
        p = 1;
        for (int j = 0; j < v; j++) p = (p * base) % 17;
        return 4'((p + offset) % 16);
    endfunction

    initial begin
        for (int v = 0; v < 16; v++) begin
            lo_tab[v] = pow_entry(3, 2, v);
            hi_tab[v] = pow_entry(5, 7, v);
        end
    end

    function automatic logic [HALF_W-1:0] mix(input logic [HALF_W-1:0] r,
                                              input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] t;
        logic [HALF_W-1:0] s;
        t = r ^ k;
        s = {hi_tab[t[7:4]], lo_tab[t[3:0]]};
        return (s << 3) | (s >> 5);
    endfunction

    function automatic block_t encrypt(input logic [HALF_W-1:0] l, input logic [HALF_W-1:0] r);
        int                keys_used;
        logic [HALF_W-1:0] l_v;
        logic [HALF_W-1:0] r_v;
        logic [HALF_W-1:0] nxt;
        logic [HALF_W-1:0] k;
        block_t            b;
        // zero length falls back to one byte, oversize saturates
        if (len_reg == 0) keys_used = 1;
        else if (len_reg > MAX_KEY_BYTES) keys_used = MAX_KEY_BYTES;
        else keys_used = len_reg;
        l_v = l;
        r_v = r;
        for (int i = 0; i < rounds_reg; i++) begin
            k   = key_reg[8 * (i % keys_used) +: 8];
            nxt = mix(r_v, k) ^ l_v;
            l_v = r_v;
            r_v = nxt;
        end
        b.left_half  = l_v;
        b.right_half = r_v;
        return b;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        block_t got;
        block_t want;
        if (!aresetn) begin
            key_reg    = '0;
            len_reg    = KEY_LEN_RESET;
            rounds_reg = ROUND_COUNT_RESET;
            ciphertext_q.delete();
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (ciphertext_q.size() == 0) begin
                    report($sformatf("result %h with no request outstanding", m_tdata));
                end else begin
                    want = ciphertext_q.pop_front();
                    if (got.left_half !== want.left_half)
                        report($sformatf("left_out %h, expected %h", got.left_half,
                                         want.left_half));
                    if (got.right_half !== want.right_half)
                        report($sformatf("right_out %h, expected %h", got.right_half,
                                         want.right_half));
                end
            end
            if (s_tvalid && s_tready)
                ciphertext_q.push_back(encrypt(s_tdata[7:0], s_tdata[15:8]));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_BYTES:   key_reg    = cfg_data;
                    REG_KEY_LEN:     len_reg    = cfg_data[LEN_W-1:0];
                    REG_ROUND_COUNT: rounds_reg = cfg_data[ROUND_W-1:0];
                    default: ;
                endcase
            end
            pending <= ciphertext_q.size();
            if (wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (ciphertext_q.size() != 0)
                    report($sformatf("%0d results never arrived", ciphertext_q.size()));
            end
        end
    end

endmodule

/* tb/tb_feistel_block_cipher_16bit.sv */
// testbench top for the 16-bit feistel cipher: clock, reset, stimulus and verdict
module tb_feistel_block_cipher_16bit;
    import fbc_pkg::*;

    localparam int KEY_BYTES       = 8;
    localparam int CLOCK_LIMIT     = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 400;
    // longest request is 255 rounds plus load and unload
    localparam int SETTLE_CYCLES   = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // left_in [7:0], right_in [15:8]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // left_out [7:0], right_out [15:8]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  wrap_up;
    int                    pending;
    int                    fail_count;
    int                    cycles = 0;
    int                    hold_reqs = 0;
    bit                    s_quiet = 1'b0;
    bit                    m_quiet = 1'b0;

    always #5 aclk = ~aclk;

    feistel_block_cipher_16bit #(
        .MAX_KEY_BYTES(KEY_BYTES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    fbc_checker #(
        .MAX_KEY_BYTES(KEY_BYTES)
    ) cipher_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wrap_up   (wrap_up),
        .pending   (pending),
        .fail_count(fail_count)
    );

    // mostly no gap, some short ones, a few long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_block(input logic [HALF_W-1:0] l, input logic [HALF_W-1:0] r);
        int gap;
        gap = s_quiet ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata  <= {r, l};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // leaves cfg_valid high, the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] key,
                                 input logic [CFG_DATA_W-1:0] len_word,
                                 input logic [CFG_DATA_W-1:0] rounds_word);
        logic [CFG_IDX_W-1:0] stray;
        stray = CFG_IDX_W'($urandom_range(REG_ROUND_COUNT + 1, 255));
        write_reg(REG_KEY_BYTES, key);
        write_reg(REG_KEY_LEN, len_word);
        write_reg(REG_ROUND_COUNT, rounds_word);
        // unknown index must leave the settings alone
        write_reg(stray, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, plus the long hold-off on request
    initial begin
        int holds_done;
        int stall;
        holds_done = 0;
        m_axis_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (holds_done != hold_reqs) begin
                holds_done = hold_reqs;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = m_quiet ? 0 : idle_len();
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        while (cycles < CLOCK_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] key;
        logic [LEN_W-1:0]      nib;
        logic [ROUND_W-1:0]    rounds;
        int                    n;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        wrap_up       = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero key, eight bytes, eight rounds
        send_block(8'h00, 8'h00);
        send_block(8'hFF, 8'hFF);
        send_block(8'h00, 8'hFF);
        send_block(8'hFF, 8'h00);
        send_block(8'hA5, 8'h5A);
        drain();

        // key length zero uses byte 0 every round, junk above the register widths
        load_settings(64'h0123_4567_89AB_CDEF, {60'hFFF_FFFF_FFFF_FFFF, 4'd0},
                      {56'hDE_ADBE_EF00_0001, 8'd5});
        send_block(8'h12, 8'h34);
        send_block(8'hFF, 8'h00);
        send_block(8'h00, 8'hFF);
        drain();

        // key length above the maximum saturates
        load_settings(64'hFEDC_BA98_7654_3210, {60'h0, 4'd15}, 64'd16);
        send_block(8'h80, 8'h01);
        send_block(8'h7F, 8'hFE);
        send_block(8'hC3, 8'h3C);
        drain();

        // zero rounds pass the block through
        load_settings(64'h1122_3344_5566_7788, 64'd8, 64'd0);
        send_block(8'h01, 8'h80);
        send_block(8'hFF, 8'hFF);
        send_block(8'h00, 8'h00);
        drain();

        load_settings('1, 64'd8, 64'd255);
        send_block(8'h00, 8'h00);
        send_block(8'hFF, 8'hFF);
        send_block(8'h5A, 8'hA5);
        drain();

        for (int p = 0; p < 14; p++) begin
            junk = {$urandom, $urandom};
            case (p)
                0:       key = '0;
                1:       key = '1;
                default: key = {$urandom, $urandom};
            endcase
            case (p)
                0:       nib = 4'd1;
                1:       nib = 4'd8;
                default: nib = LEN_W'($urandom_range(0, 15));
            endcase
            case (p)
                2:       rounds = 8'd255;
                3:       rounds = 8'd0;
                4:       rounds = 8'd1;
                default: rounds = ROUND_W'($urandom_range(2, 24));
            endcase
            n = (p == 2) ? 20 : 130;
            s_quiet = ($urandom_range(0, 3) == 0);
            m_quiet <= ($urandom_range(0, 3) == 0);
            load_settings(key, {junk[63:4], nib}, {junk[63:8], rounds});
            // receiver stops for a long stretch while requests keep coming
            if (p == 6) hold_reqs <= hold_reqs + 1;
            repeat (n) send_block(HALF_W'($urandom_range(0, 255)), HALF_W'($urandom_range(0, 255)));
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
